[src/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RVDX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RVDX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define RVDX_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/rvdx_pkg.sv]
package rvdx_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned SHAMT_W = 5;

   localparam logic [6:0] OPC_R      = 7'b0110011;
   localparam logic [6:0] OPC_IMM    = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;

   localparam logic [XLEN-1:0] UPPER_MASK = 32'hFFFFF000;

   localparam logic [2:0] F3_ADD_SUB = 3'b000;
   localparam logic [2:0] F3_AND     = 3'b111;
   localparam logic [2:0] F3_SRA     = 3'b101;
   localparam logic [2:0] F3_OR      = 3'b110;
   localparam logic [2:0] F3_SLTU    = 3'b011;

   typedef enum logic [1:0] {
      CLS_ADD = 2'd0,
      CLS_SUB = 2'd1,
      CLS_REG = 2'd2,
      CLS_IMM = 2'd3
   } alu_class_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_AND,
      ALU_OR,
      ALU_SRA,
      ALU_SLTU,
      ALU_NONE
   } alu_op_type;

   typedef struct packed {
      logic reg_write;
      logic mem_read;
      logic mem_write;
      logic mem_to_reg;
      logic branch;
      logic jump_register;
      logic upper_immediate;
      logic alu_src;
   } ctrl_type;

endpackage

[src/rvdx_if.sv]
interface rvdx_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] instruction;
   logic signed [31:0] rs1_value;
   logic signed [31:0] rs2_value;

   modport source (output valid, output instruction, output rs1_value, output rs2_value,
                   input ready);
   modport sink   (input valid, input instruction, input rs1_value, input rs2_value,
                   output ready);
endinterface

interface rvdx_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] alu_result;
   logic               zero_flag;
   logic signed [31:0] immediate;
   logic               reg_write;
   logic               mem_read;
   logic               mem_write;
   logic               mem_to_reg;
   logic               branch;
   logic               jump_register;
   logic               upper_immediate;

   modport source (output valid, output alu_result, output zero_flag, output immediate,
                   output reg_write, output mem_read, output mem_write, output mem_to_reg,
                   output branch, output jump_register, output upper_immediate,
                   input ready);
   modport sink   (input valid, input alu_result, input zero_flag, input immediate,
                   input reg_write, input mem_read, input mem_write, input mem_to_reg,
                   input branch, input jump_register, input upper_immediate,
                   output ready);
endinterface

[src/rv32i_subset_decode_execute.sv]
// Decode and execute stage for a subset of RV32I. Each request carries one
// instruction word and the two source register values; each response gives
// the ALU result, its zero flag, the sign-extended I/S/B/U immediate and the
// main control bits (reg_write, mem_read, mem_write, mem_to_reg, branch,
// jump_register, upper_immediate). A request passes one input register, decode
// and ALU logic and one result register. Throughput is one request per cycle,
// sustained as long as the response side keeps ready high. When the response
// side stalls, the result register holds, and the input register still takes
// one more request, so at most two requests are in flight. req.ready is
// combinational on rsp.ready, and is also high while either register is empty.
// Funct7 is ignored (R-type funct3 000 always subtracts, 101 always shifts
// arithmetically), undefined funct3 codes give a zero result, and an unknown
// opcode clears all controls and the immediate and adds rs1 and rs2.
module rv32i_subset_decode_execute
   import rvdx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rvdx_req_if.sink   req,
   rvdx_rsp_if.source rsp
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   logic [XLEN-1:0] instr_ff;
   logic [XLEN-1:0] rs1_ff;
   logic [XLEN-1:0] rs2_ff;

   // Result register
   logic            out_valid_ff, out_valid_in;
   logic [XLEN-1:0] result_ff;
   logic            zero_ff;
   logic [XLEN-1:0] imm_ff;
   ctrl_type        ctrl_ff;

   // Decode and execute logic
   ctrl_type        ctrl;
   alu_op_type      alu_op;
   logic [XLEN-1:0] immediate;
   logic [XLEN-1:0] alu_result;
   logic            zero_flag;

   logic req_accept;
   logic advance;

   // Advance the result register when it is empty or being drained.
   assign advance    = !out_valid_ff || rsp.ready;
   assign req.ready  = !in_valid_ff || advance;
   assign req_accept = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         instr_ff <= req.instruction;
         rs1_ff   <= $unsigned(req.rs1_value);
         rs2_ff   <= $unsigned(req.rs2_value);
      end
   end

   rvdx_decode u_decode (
      .instruction (instr_ff),
      .ctrl        (ctrl),
      .immediate   (immediate),
      .alu_op      (alu_op)
   );

   rvdx_alu u_alu (
      .alu_op     (alu_op),
      .ctrl       (ctrl),
      .rs1_value  (rs1_ff),
      .rs2_value  (rs2_ff),
      .immediate  (immediate),
      .alu_result (alu_result),
      .zero_flag  (zero_flag)
   );

   // Load the result register; hold it while the response is stalled.
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         result_ff <= alu_result;
         zero_ff   <= zero_flag;
         imm_ff    <= immediate;
         ctrl_ff   <= ctrl;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.alu_result      = $signed(result_ff);
   assign rsp.zero_flag       = zero_ff;
   assign rsp.immediate       = $signed(imm_ff);
   assign rsp.reg_write       = ctrl_ff.reg_write;
   assign rsp.mem_read        = ctrl_ff.mem_read;
   assign rsp.mem_write       = ctrl_ff.mem_write;
   assign rsp.mem_to_reg      = ctrl_ff.mem_to_reg;
   assign rsp.branch          = ctrl_ff.branch;
   assign rsp.jump_register   = ctrl_ff.jump_register;
   assign rsp.upper_immediate = ctrl_ff.upper_immediate;

endmodule

[src/rvdx_decode.sv]
module rvdx_decode
   import rvdx_pkg::*;
(
   input  logic [XLEN-1:0] instruction,
   output ctrl_type        ctrl,
   output logic [XLEN-1:0] immediate,
   output alu_op_type      alu_op
);

   logic [6:0]    opcode;
   logic [2:0]    funct3;
   alu_class_type alu_class;

   assign opcode = instruction[6:0];
   assign funct3 = instruction[14:12];

   // Controls, ALU class and immediate format from the opcode.
   always_comb begin
      ctrl      = '0;
      alu_class = CLS_ADD;
      immediate = '0;
      unique case (opcode)
         OPC_R: begin
            ctrl.reg_write = 1'b1;
            alu_class      = CLS_REG;
         end
         OPC_IMM: begin
            ctrl.reg_write = 1'b1;
            ctrl.alu_src   = 1'b1;
            alu_class      = CLS_IMM;
            immediate      = {{20{instruction[31]}}, instruction[31:20]};
         end
         OPC_LOAD: begin
            ctrl.reg_write  = 1'b1;
            ctrl.mem_read   = 1'b1;
            ctrl.mem_to_reg = 1'b1;
            ctrl.alu_src    = 1'b1;
            immediate       = {{20{instruction[31]}}, instruction[31:20]};
         end
         OPC_STORE: begin
            ctrl.mem_write = 1'b1;
            ctrl.alu_src   = 1'b1;
            immediate      = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
         end
         OPC_BRANCH: begin
            ctrl.branch = 1'b1;
            alu_class   = CLS_SUB;
            immediate   = {{19{instruction[31]}}, instruction[31], instruction[7],
                           instruction[30:25], instruction[11:8], 1'b0};
         end
         OPC_JALR: begin
            ctrl.jump_register = 1'b1;
            ctrl.reg_write     = 1'b1;
            ctrl.alu_src       = 1'b1;
            immediate          = {{20{instruction[31]}}, instruction[31:20]};
         end
         OPC_LUI: begin
            ctrl.upper_immediate = 1'b1;
            ctrl.reg_write       = 1'b1;
            ctrl.alu_src         = 1'b1;
            immediate            = instruction & UPPER_MASK;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // Class plus funct3 to ALU operation; funct7 is not looked at.
   always_comb begin
      alu_op = ALU_NONE;
      unique case (alu_class)
         CLS_ADD: alu_op = ALU_ADD;
         CLS_SUB: alu_op = ALU_SUB;
         CLS_REG: begin
            unique case (funct3)
               F3_ADD_SUB: alu_op = ALU_SUB;
               F3_AND:     alu_op = ALU_AND;
               F3_SRA:     alu_op = ALU_SRA;
               default:    alu_op = ALU_NONE;
            endcase
         end
         CLS_IMM: begin
            unique case (funct3)
               F3_ADD_SUB: alu_op = ALU_ADD;
               F3_OR:      alu_op = ALU_OR;
               F3_SLTU:    alu_op = ALU_SLTU;
               default:    alu_op = ALU_NONE;
            endcase
         end
         default: alu_op = ALU_NONE;
      endcase
   end

endmodule

[src/rvdx_alu.sv]
module rvdx_alu
   import rvdx_pkg::*;
(
   input  alu_op_type      alu_op,
   input  ctrl_type        ctrl,
   input  logic [XLEN-1:0] rs1_value,
   input  logic [XLEN-1:0] rs2_value,
   input  logic [XLEN-1:0] immediate,
   output logic [XLEN-1:0] alu_result,
   output logic            zero_flag
);

   logic [XLEN-1:0]    operand_b;
   logic [XLEN-1:0]    op_result;
   logic [SHAMT_W-1:0] shamt;

   assign operand_b = ctrl.alu_src ? immediate : rs2_value;
   assign shamt     = operand_b[SHAMT_W-1:0];

   always_comb begin
      case (alu_op)
         ALU_ADD:  op_result = rs1_value + operand_b;
         ALU_SUB:  op_result = rs1_value - operand_b;
         ALU_AND:  op_result = rs1_value & operand_b;
         ALU_OR:   op_result = rs1_value | operand_b;
         ALU_SRA:  op_result = $unsigned($signed(rs1_value) >>> shamt);
         ALU_SLTU: op_result = {{(XLEN-1){1'b0}}, (rs1_value < operand_b)};
         default:  op_result = '0;
      endcase
   end

   // LUI passes the immediate straight through.
   assign alu_result = ctrl.upper_immediate ? operand_b : op_result;
   assign zero_flag  = (alu_result == '0);

endmodule

[src/rvdx_checker.sv]
`include "assert_macros.svh"

module rvdx_checker
   import rvdx_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [XLEN-1:0] rsp_alu_result,
   input logic [XLEN-1:0] rsp_immediate
);

   logic [2:0] inflight_ff, inflight_in;
   logic       req_accept;
   logic       rsp_accept;

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;

   // Track requests taken but not yet answered.
   always_comb begin
      inflight_in = inflight_ff;
      if (req_accept && !rsp_accept) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (!req_accept && rsp_accept) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `RVDX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alu_result) && $stable(rsp_immediate), "stalled response changed")
   `RVDX_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "response valid right after reset")
   `RVDX_ASSERT_NOW(a_inflight_max, clock, reset, 1'b1, inflight_ff <= 3'd2, "more than two requests in flight")
   `RVDX_ASSERT_NOW(a_no_phantom, clock, reset, rsp_valid, inflight_ff != 3'd0, "response without request")
   `RVDX_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with empty output")

endmodule

bind rv32i_subset_decode_execute rvdx_checker u_rvdx_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_alu_result (rsp.alu_result),
   .rsp_immediate  (rsp.immediate)
);
